FILE: rtl/core/lc_pkg.sv
package lc_pkg;

    localparam int CLIP_WIDTH      = 15;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CODE_WIDTH      = 4;
    localparam int PASS_WIDTH      = 4;

    localparam logic [CLIP_WIDTH-1:0] CLIP_X_MAX_RESET = 15'd127;
    localparam logic [CLIP_WIDTH-1:0] CLIP_Y_MAX_RESET = 15'd63;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CLIP_X_MAX = 1'b0,
        REG_CLIP_Y_MAX = 1'b1
    } cfg_reg_t;

    localparam logic [CODE_WIDTH-1:0] CODE_LEFT   = 4'b0001;
    localparam logic [CODE_WIDTH-1:0] CODE_RIGHT  = 4'b0010;
    localparam logic [CODE_WIDTH-1:0] CODE_TOP    = 4'b0100;
    localparam logic [CODE_WIDTH-1:0] CODE_BOTTOM = 4'b1000;
    localparam logic [CODE_WIDTH-1:0] CODE_INSIDE = 4'b0000;

    localparam logic [PASS_WIDTH-1:0] MAX_PASSES = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TEST = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } clip_state_t;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    typedef struct packed {
        logic done;
        logic neg;
    } md_status_t;

endpackage

FILE: rtl/core/lc_seg_if.sv
interface lc_seg_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

FILE: rtl/core/lc_clip_if.sv
interface lc_clip_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic                          line_visible;
    logic signed [COORD_WIDTH-1:0] clipped_start_x;
    logic signed [COORD_WIDTH-1:0] clipped_start_y;
    logic signed [COORD_WIDTH-1:0] clipped_end_x;
    logic signed [COORD_WIDTH-1:0] clipped_end_y;

    modport source (output valid, output line_visible, output clipped_start_x,
                    output clipped_start_y, output clipped_end_x,
                    output clipped_end_y, input ready);
    modport sink   (input valid, input line_visible, input clipped_start_x,
                    input clipped_start_y, input clipped_end_x,
                    input clipped_end_y, output ready);
endinterface

FILE: rtl/core/lc_muldiv.sv
module lc_muldiv #(
    parameter int MAG_WIDTH = 18
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [MAG_WIDTH-1:0] op_a,
    input  logic signed [MAG_WIDTH-1:0] op_b,
    input  logic signed [MAG_WIDTH-1:0] op_d,
    output lc_pkg::md_status_t          status,
    output logic        [MAG_WIDTH-1:0] quot
);
    import lc_pkg::*;

    localparam int CNT_WIDTH  = $clog2(MAG_WIDTH);
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;
    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(MAG_WIDTH - 1);

    md_state_t              state_reg, state_next;
    logic [MAG_WIDTH-1:0]   mag_a_reg, mag_a_next;
    logic [MAG_WIDTH-1:0]   mag_d_reg, mag_d_next;
    logic [PROD_WIDTH-1:0]  prod_reg, prod_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   dz_reg, dz_next;
    logic                   done_reg, done_next;

    logic [MAG_WIDTH:0]     add_a;
    logic [MAG_WIDTH:0]     add_b;
    logic                   add_cin;
    logic [MAG_WIDTH+1:0]   add_sum;
    logic                   div_ok;

    function automatic logic [MAG_WIDTH-1:0] magnitude(input logic signed [MAG_WIDTH-1:0] v);
        magnitude = v[MAG_WIDTH-1] ? MAG_WIDTH'(~v + 1'b1) : MAG_WIDTH'(v);
    endfunction

    // One adder serves both the shift-add multiply and the restoring divide.
    always_comb
    begin
        if (state_reg == MD_DIV)
        begin
            add_a   = prod_reg[PROD_WIDTH-1:MAG_WIDTH-1];
            add_b   = ~{1'b0, mag_d_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = {1'b0, prod_reg[PROD_WIDTH-1:MAG_WIDTH]};
            add_b   = prod_reg[0] ? {1'b0, mag_a_reg} : '0;
            add_cin = 1'b0;
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(MAG_WIDTH+1){1'b0}}, add_cin};
        div_ok  = add_sum[MAG_WIDTH+1];
    end

    always_comb
    begin
        state_next = state_reg;
        mag_a_next = mag_a_reg;
        mag_d_next = mag_d_reg;
        prod_next  = prod_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        dz_next    = dz_reg;
        done_next  = 1'b0;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    mag_a_next = magnitude(op_a);
                    mag_d_next = magnitude(op_d);
                    prod_next  = {{MAG_WIDTH{1'b0}}, magnitude(op_b)};
                    neg_next   = op_a[MAG_WIDTH-1] ^ op_b[MAG_WIDTH-1] ^ op_d[MAG_WIDTH-1];
                    dz_next    = (op_d == '0);
                    cnt_next   = LAST_STEP;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                prod_next = {add_sum[MAG_WIDTH:0], prod_reg[MAG_WIDTH-1:1]};
                if (cnt_reg == '0)
                begin
                    cnt_next   = LAST_STEP;
                    state_next = MD_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_DIV:
            begin
                prod_next = {div_ok ? add_sum[MAG_WIDTH-1:0]
                                    : prod_reg[PROD_WIDTH-2:MAG_WIDTH-1],
                             prod_reg[MAG_WIDTH-2:0], div_ok};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag_a_next;
        mag_d_reg <= mag_d_next;
        prod_reg  <= prod_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        dz_reg    <= dz_next;
    end

    assign status.done = done_reg;
    assign status.neg  = neg_reg;
    assign quot        = dz_reg ? '0 : prod_reg[MAG_WIDTH-1:0];

endmodule

FILE: rtl/core/line_clipper_unit.sv
// An accepted segment goes through from 0 to 8 clip passes (MAX_PASSES) before its
// result is registered; each pass runs one multiply and one divide in lc_muldiv.
// The input is ready only while the sequencer is idle, so no new segment is taken
// before the last result is registered; a result awaiting transfer holds the sequencer.
// Reset: asynchronous, active low; clears the sequencer and output valid and sets
// clip_x_max to 127 and clip_y_max to 63.
module line_clipper_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lc_pkg::CLIP_WIDTH-1:0]      cfg_data,
    lc_seg_if.sink                             seg,
    lc_clip_if.source                          clip
);
    import lc_pkg::*;

    localparam int INT_WIDTH  = ((COORD_WIDTH > CLIP_WIDTH + 1) ? COORD_WIDTH
                                                                : CLIP_WIDTH + 1) + 1;
    localparam int DIFF_WIDTH = INT_WIDTH + 1;

    clip_state_t                  state_reg, state_next;
    logic [CLIP_WIDTH-1:0]        clip_x_max_reg, clip_y_max_reg;
    logic signed [INT_WIDTH-1:0]  x0_reg, x0_next, y0_reg, y0_next;
    logic signed [INT_WIDTH-1:0]  x1_reg, x1_next, y1_reg, y1_next;
    logic [PASS_WIDTH-1:0]        pass_reg, pass_next;
    logic                         edge_y_reg, edge_y_next;
    logic signed [INT_WIDTH-1:0]  edge_val_reg, edge_val_next;
    logic                         move0_reg, move0_next;
    logic                         visible_reg, visible_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_visible_reg, out_visible_next;
    logic signed [COORD_WIDTH-1:0] out_x0_reg, out_x0_next, out_y0_reg, out_y0_next;
    logic signed [COORD_WIDTH-1:0] out_x1_reg, out_x1_next, out_y1_reg, out_y1_next;

    logic signed [INT_WIDTH-1:0]  xm, ym;
    logic [CODE_WIDTH-1:0]        code0, code1, clip_code;
    logic signed [DIFF_WIDTH-1:0] dx, dy;
    logic signed [DIFF_WIDTH-1:0] op_a, op_b, op_d;
    logic                         sel_edge_y;
    logic signed [INT_WIDTH-1:0]  sel_edge_val;
    logic                         md_start;
    md_status_t                   md_status;
    logic [DIFF_WIDTH-1:0]        md_quot;
    logic signed [DIFF_WIDTH:0]   base_ext, quot_ext, new_sum;
    logic signed [INT_WIDTH-1:0]  new_coord;

    function automatic logic [CODE_WIDTH-1:0] region(
        input logic signed [INT_WIDTH-1:0] x,
        input logic signed [INT_WIDTH-1:0] y,
        input logic signed [INT_WIDTH-1:0] x_max,
        input logic signed [INT_WIDTH-1:0] y_max
    );
        logic [CODE_WIDTH-1:0] c;
        c = CODE_INSIDE;
        if (x < 0)
            c = c | CODE_LEFT;
        else if (x > x_max)
            c = c | CODE_RIGHT;
        if (y < 0)
            c = c | CODE_TOP;
        else if (y > y_max)
            c = c | CODE_BOTTOM;
        return c;
    endfunction

    assign xm = signed'({{(INT_WIDTH-CLIP_WIDTH){1'b0}}, clip_x_max_reg});
    assign ym = signed'({{(INT_WIDTH-CLIP_WIDTH){1'b0}}, clip_y_max_reg});

    assign code0     = region(x0_reg, y0_reg, xm, ym);
    assign code1     = region(x1_reg, y1_reg, xm, ym);
    assign clip_code = (code0 != CODE_INSIDE) ? code0 : code1;

    assign dx = DIFF_WIDTH'(x1_reg) - DIFF_WIDTH'(x0_reg);
    assign dy = DIFF_WIDTH'(y1_reg) - DIFF_WIDTH'(y0_reg);

    // The intersection is always measured from the start point.
    always_comb
    begin
        if ((clip_code & CODE_BOTTOM) != CODE_INSIDE)
        begin
            op_a         = dx;
            op_b         = DIFF_WIDTH'(ym) - DIFF_WIDTH'(y0_reg);
            op_d         = dy;
            sel_edge_y   = 1'b1;
            sel_edge_val = ym;
        end
        else if ((clip_code & CODE_TOP) != CODE_INSIDE)
        begin
            op_a         = dx;
            op_b         = -DIFF_WIDTH'(y0_reg);
            op_d         = dy;
            sel_edge_y   = 1'b1;
            sel_edge_val = '0;
        end
        else if ((clip_code & CODE_RIGHT) != CODE_INSIDE)
        begin
            op_a         = dy;
            op_b         = DIFF_WIDTH'(xm) - DIFF_WIDTH'(x0_reg);
            op_d         = dx;
            sel_edge_y   = 1'b0;
            sel_edge_val = xm;
        end
        else
        begin
            op_a         = dy;
            op_b         = -DIFF_WIDTH'(x0_reg);
            op_d         = dx;
            sel_edge_y   = 1'b0;
            sel_edge_val = '0;
        end
    end

    lc_muldiv #(
        .MAG_WIDTH (DIFF_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .op_a   (op_a),
        .op_b   (op_b),
        .op_d   (op_d),
        .status (md_status),
        .quot   (md_quot)
    );

    assign base_ext  = (DIFF_WIDTH+1)'(edge_y_reg ? x0_reg : y0_reg);
    assign quot_ext  = signed'({1'b0, md_quot});
    assign new_sum   = md_status.neg ? (base_ext - quot_ext) : (base_ext + quot_ext);
    assign new_coord = INT_WIDTH'(new_sum);

    always_comb
    begin
        state_next       = state_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        pass_next        = pass_reg;
        edge_y_next      = edge_y_reg;
        edge_val_next    = edge_val_reg;
        move0_next       = move0_reg;
        visible_next     = visible_reg;
        out_valid_next   = out_valid_reg && !clip.ready;
        out_visible_next = out_visible_reg;
        out_x0_next      = out_x0_reg;
        out_y0_next      = out_y0_reg;
        out_x1_next      = out_x1_reg;
        out_y1_next      = out_y1_reg;
        md_start         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (seg.valid)
                begin
                    x0_next    = INT_WIDTH'(seg.start_x);
                    y0_next    = INT_WIDTH'(seg.start_y);
                    x1_next    = INT_WIDTH'(seg.end_x);
                    y1_next    = INT_WIDTH'(seg.end_y);
                    pass_next  = '0;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if ((code0 | code1) == CODE_INSIDE)
                begin
                    visible_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (((code0 & code1) != CODE_INSIDE) || (pass_reg == MAX_PASSES))
                begin
                    visible_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    md_start      = 1'b1;
                    pass_next     = pass_reg + 1'b1;
                    edge_y_next   = sel_edge_y;
                    edge_val_next = sel_edge_val;
                    move0_next    = (code0 != CODE_INSIDE);
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (md_status.done)
                begin
                    if (move0_reg)
                    begin
                        x0_next = edge_y_reg ? new_coord : edge_val_reg;
                        y0_next = edge_y_reg ? edge_val_reg : new_coord;
                    end
                    else
                    begin
                        x1_next = edge_y_reg ? new_coord : edge_val_reg;
                        y1_next = edge_y_reg ? edge_val_reg : new_coord;
                    end
                    state_next = ST_TEST;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || clip.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_visible_next = visible_reg;
                    out_x0_next      = visible_reg ? COORD_WIDTH'(x0_reg) : '0;
                    out_y0_next      = visible_reg ? COORD_WIDTH'(y0_reg) : '0;
                    out_x1_next      = visible_reg ? COORD_WIDTH'(x1_reg) : '0;
                    out_y1_next      = visible_reg ? COORD_WIDTH'(y1_reg) : '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_x_max_reg <= CLIP_X_MAX_RESET;
            clip_y_max_reg <= CLIP_Y_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CLIP_X_MAX: clip_x_max_reg <= cfg_data;
                REG_CLIP_Y_MAX: clip_y_max_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg          <= x0_next;
        y0_reg          <= y0_next;
        x1_reg          <= x1_next;
        y1_reg          <= y1_next;
        edge_y_reg      <= edge_y_next;
        edge_val_reg    <= edge_val_next;
        move0_reg       <= move0_next;
        visible_reg     <= visible_next;
        out_visible_reg <= out_visible_next;
        out_x0_reg      <= out_x0_next;
        out_y0_reg      <= out_y0_next;
        out_x1_reg      <= out_x1_next;
        out_y1_reg      <= out_y1_next;
    end

    assign seg.ready            = (state_reg == ST_IDLE);
    assign clip.valid           = out_valid_reg;
    assign clip.line_visible    = out_visible_reg;
    assign clip.clipped_start_x = out_x0_reg;
    assign clip.clipped_start_y = out_y0_reg;
    assign clip.clipped_end_x   = out_x1_reg;
    assign clip.clipped_end_y   = out_y1_reg;

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg <= MAX_PASSES)
        else $error("clip pass count exceeded its bound");

    a_accept_to_test: assert property (@(posedge clk) disable iff (!rst_n)
        seg.valid && seg.ready |=> state_reg == ST_TEST)
        else $error("accepted segment did not enter the outcode test");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_status.done |-> state_reg == ST_WAIT)
        else $error("divider finished outside of the wait state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result became valid without a finished segment");

endmodule

FILE: tb/clip_checker.sv
module clip_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lc_pkg::CLIP_WIDTH-1:0]      cfg_data,
    lc_seg_if                                  seg,
    lc_clip_if                                 clip,
    output int                                 fail_count,
    output int                                 clips_outstanding
);
    import lc_pkg::*;

    typedef struct packed {
        logic                          visible;
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] ex;
        logic signed [COORD_WIDTH-1:0] ey;
    } clip_result_t;

    logic [CLIP_WIDTH-1:0] window_x_max = CLIP_X_MAX_RESET;
    logic [CLIP_WIDTH-1:0] window_y_max = CLIP_Y_MAX_RESET;
    clip_result_t          expected_clips[$];
    int                    fail_total = 0;
    int                    mismatch_reports = 0;
    int                    pending_total = 0;

    assign fail_count        = fail_total;
    assign clips_outstanding = pending_total;

    function automatic logic [CODE_WIDTH-1:0] region_code(longint x, longint y,
                                                          longint xm, longint ym);
        logic [CODE_WIDTH-1:0] c;
        c = CODE_INSIDE;
        if (x < 0)
            c = c | CODE_LEFT;
        else if (x > xm)
            c = c | CODE_RIGHT;
        if (y < 0)
            c = c | CODE_TOP;
        else if (y > ym)
            c = c | CODE_BOTTOM;
        return c;
    endfunction

    function automatic longint scaled_offset(longint a, longint b, longint d);
        if (d == 0)
            return 0;
        return (a * b) / d;
    endfunction

    function automatic clip_result_t clip_segment(logic signed [COORD_WIDTH-1:0] ax,
                                                  logic signed [COORD_WIDTH-1:0] ay,
                                                  logic signed [COORD_WIDTH-1:0] bx,
                                                  logic signed [COORD_WIDTH-1:0] by,
                                                  logic [CLIP_WIDTH-1:0] xmax_r,
                                                  logic [CLIP_WIDTH-1:0] ymax_r);
        longint                x0, y0, x1, y1, xm, ym, nx, ny;
        logic [CODE_WIDTH-1:0] c0, c1, co;
        logic                  accepted;
        clip_result_t          r;
        x0 = ax;
        y0 = ay;
        x1 = bx;
        y1 = by;
        xm = longint'(xmax_r);
        ym = longint'(ymax_r);
        c0 = region_code(x0, y0, xm, ym);
        c1 = region_code(x1, y1, xm, ym);
        accepted = 1'b0;
        for (int pass = 0; pass <= int'(MAX_PASSES); pass++)
        begin
            if ((c0 | c1) == CODE_INSIDE)
            begin
                accepted = 1'b1;
                break;
            end
            if ((c0 & c1) != CODE_INSIDE || pass == int'(MAX_PASSES))
                break;
            co = (c0 != CODE_INSIDE) ? c0 : c1;
            if ((co & CODE_BOTTOM) != CODE_INSIDE)
            begin
                nx = x0 + scaled_offset(x1 - x0, ym - y0, y1 - y0);
                ny = ym;
            end
            else if ((co & CODE_TOP) != CODE_INSIDE)
            begin
                nx = x0 + scaled_offset(x1 - x0, -y0, y1 - y0);
                ny = 0;
            end
            else if ((co & CODE_RIGHT) != CODE_INSIDE)
            begin
                ny = y0 + scaled_offset(y1 - y0, xm - x0, x1 - x0);
                nx = xm;
            end
            else
            begin
                ny = y0 + scaled_offset(y1 - y0, -x0, x1 - x0);
                nx = 0;
            end
            if (c0 != CODE_INSIDE)
            begin
                x0 = nx;
                y0 = ny;
                c0 = region_code(x0, y0, xm, ym);
            end
            else
            begin
                x1 = nx;
                y1 = ny;
                c1 = region_code(x1, y1, xm, ym);
            end
        end
        r = '0;
        r.visible = accepted;
        if (accepted)
        begin
            r.sx = x0[COORD_WIDTH-1:0];
            r.sy = y0[COORD_WIDTH-1:0];
            r.ex = x1[COORD_WIDTH-1:0];
            r.ey = y1[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clip_result_t got;
        clip_result_t want;
        if (!rst_n)
        begin
            window_x_max = CLIP_X_MAX_RESET;
            window_y_max = CLIP_Y_MAX_RESET;
            expected_clips.delete();
        end
        else
        begin
            if (seg.valid && seg.ready)
                expected_clips.push_back(clip_segment(seg.start_x, seg.start_y,
                                                      seg.end_x, seg.end_y,
                                                      window_x_max, window_y_max));
            if (clip.valid && clip.ready)
            begin
                got.visible = clip.line_visible;
                got.sx      = clip.clipped_start_x;
                got.sy      = clip.clipped_start_y;
                got.ex      = clip.clipped_end_x;
                got.ey      = clip.clipped_end_y;
                if (expected_clips.size() == 0)
                begin
                    fail_total++;
                    if (mismatch_reports < 10)
                    begin
                        mismatch_reports++;
                        $display("unexpected result transfer: visible=%0d (%0d,%0d)-(%0d,%0d)",
                                 got.visible, got.sx, got.sy, got.ex, got.ey);
                    end
                end
                else
                begin
                    want = expected_clips.pop_front();
                    if (got !== want)
                    begin
                        fail_total++;
                        if (mismatch_reports < 10)
                        begin
                            mismatch_reports++;
                            $display("clip mismatch: expected visible=%0d (%0d,%0d)-(%0d,%0d)",
                                     want.visible, want.sx, want.sy, want.ex, want.ey);
                            $display("               actual   visible=%0d (%0d,%0d)-(%0d,%0d)",
                                     got.visible, got.sx, got.sy, got.ex, got.ey);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_CLIP_X_MAX)
                    window_x_max = cfg_data;
                else if (cfg_index == REG_CLIP_Y_MAX)
                    window_y_max = cfg_data;
            end
        end
        pending_total = expected_clips.size();
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import lc_pkg::*;

    localparam int CW        = 16;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN     = 200;

    localparam int PHASE_X[6] = '{127, 0, 32767, 0, 32767, 15};
    localparam int PHASE_Y[6] = '{63, 0, 32767, 32767, 0, 7};

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CLIP_WIDTH-1:0]      cfg_data  = '0;
    bit                         no_idle   = 1'b0;
    int                         fail_count;
    int                         clips_outstanding;

    int directed_segs[23][4] = '{
        '{10, 10, 100, 50}, '{0, 0, 127, 63}, '{127, 0, 0, 63}, '{-5, 10, -1, 20},
        '{130, 5, 200, 60}, '{5, -3, 120, -40}, '{5, 64, 100, 300}, '{10, -20, 40, 100},
        '{-50, 30, 60, 30}, '{60, 10, 300, 20}, '{-50, -50, 200, 150},
        '{-32768, -32768, 32767, 32767}, '{32767, -32768, -32768, 32767},
        '{5, 5, 5, 5}, '{200, 5, 200, 5}, '{300, 10, 10, 10}, '{-20, 10, 10, -20},
        '{-20, 30, 30, -20}, '{-10, 0, 200, 0}, '{0, -10, 0, 100}, '{-1, -1, 128, 64},
        '{32767, 32767, 32767, 32767}, '{-32768, 0, -32768, 0}
    };

    lc_seg_if  #(.COORD_WIDTH(CW)) seg_ch ();
    lc_clip_if #(.COORD_WIDTH(CW)) clip_ch ();

    line_clipper_unit #(
        .COORD_WIDTH(CW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .seg      (seg_ch.sink),
        .clip     (clip_ch.source)
    );

    clip_checker #(
        .COORD_WIDTH(CW)
    ) chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .seg              (seg_ch),
        .clip             (clip_ch),
        .fail_count       (fail_count),
        .clips_outstanding(clips_outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

    task automatic write_reg(cfg_reg_t idx, logic [CLIP_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_window(logic [CLIP_WIDTH-1:0] xmax, logic [CLIP_WIDTH-1:0] ymax);
        write_reg(REG_CLIP_X_MAX, xmax);
        write_reg(REG_CLIP_Y_MAX, ymax);
    endtask

    task automatic send_segment(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= ax;
        seg_ch.start_y <= ay;
        seg_ch.end_x   <= bx;
        seg_ch.end_y   <= by;
        do
            @(posedge clk);
        while (!seg_ch.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (clips_outstanding != 0)
            @(negedge clk);
    endtask

    // Coordinates mostly land near the window so that clipping passes are exercised.
    function automatic logic signed [CW-1:0] rand_coord(int limit);
        int lo;
        int hi;
        int v;
        case ($urandom_range(0, 9))
            0, 1:
                v = $urandom;
            2:
                case ($urandom_range(0, 5))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    4: v = limit;
                    default: v = limit + 1;
                endcase
            default:
            begin
                lo = -(limit / 2) - 4;
                hi = limit + limit / 2 + 4;
                if (lo < -32768)
                    lo = -32768;
                if (hi > 32767)
                    hi = 32767;
                v = lo + int'($urandom_range(0, hi - lo));
            end
        endcase
        return v[CW-1:0];
    endfunction

    initial
    begin
        int received;
        int stall;
        received      = 0;
        clip_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (received == 30 || received == 500)
            begin
                clip_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                clip_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            clip_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!clip_ch.valid);
            received++;
        end
    end

    initial
    begin
        int wx;
        int wy;
        seg_ch.valid   = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x   = '0;
        seg_ch.end_y   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_window(CLIP_X_MAX_RESET, CLIP_Y_MAX_RESET);
        foreach (directed_segs[i])
            send_segment(CW'(directed_segs[i][0]), CW'(directed_segs[i][1]),
                         CW'(directed_segs[i][2]), CW'(directed_segs[i][3]));
        seg_ch.valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            if (p < 6)
            begin
                wx = PHASE_X[p];
                wy = PHASE_Y[p];
            end
            else if (p == 6)
            begin
                wx = $urandom_range(0, 32767);
                wy = $urandom_range(0, 32767);
            end
            else
            begin
                wx = $urandom_range(0, 300);
                wy = $urandom_range(0, 300);
            end
            set_window(wx[CLIP_WIDTH-1:0], wy[CLIP_WIDTH-1:0]);
            for (int i = 0; i < 125; i++)
            begin
                if (i % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_segment(rand_coord(wx), rand_coord(wy), rand_coord(wx), rand_coord(wy));
            end
            seg_ch.valid <= 1'b0;
            no_idle = 1'b0;
            wait_drained();
        end

        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0 && clips_outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
